// ===== rtl/core/ghp_pkg.sv =====
// Package for the generational handle pool: sizes, request codes and status codes.
// No dependencies; used by generational_handle_pool.
`timescale 1ns / 1ps

package ghp_pkg;

  // Pool geometry
  localparam int SLOT_COUNT   = 64;
  localparam int IDX_W        = $clog2(SLOT_COUNT);
  localparam int GEN_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;

  // Free-slot scan: SCAN_W alive flags examined per cycle
  localparam int SCAN_W   = 8;
  localparam int SCAN_LSB = $clog2(SCAN_W);
  localparam int CHUNKS   = SLOT_COUNT / SCAN_W;
  localparam int CHUNK_W  = IDX_W - SCAN_LSB;

  // Request codes
  localparam logic [1:0] REQ_CREATE  = 2'd0;
  localparam logic [1:0] REQ_UPDATE  = 2'd1;
  localparam logic [1:0] REQ_DESTROY = 2'd2;
  localparam logic [1:0] REQ_LOOKUP  = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [GEN_BITS-1:0]     gen_t;
  typedef logic [PAYLOAD_BITS-1:0] pay_t;

endpackage

// ===== rtl/core/generational_handle_pool.sv =====
// Generational handle pool (slot map) top level: sequencer, slot memories, output register.
// Depends on ghp_pkg.
`timescale 1ns / 1ps

// A pool of 64 slots addressed by handles (index, generation). Create takes the
// lowest free slot, bumps its generation (never 0) and returns the new handle;
// update, destroy and lookup act only on a live handle whose generation matches,
// else return status 1. One transaction is processed at a time: update, destroy
// and lookup pass through the read and execute states before the next acceptance.
// Create first walks the free-slot scanner over 8-slot groups until one holds a
// free slot, then reads and executes; a create on a full pool walks all 8 groups
// and goes straight to execute. The execute step holds until the output
// register is free, so a previous result still waiting on out_stall delays it.
// The generation and payload memories are read through a registered port, then
// written when the execute step loads its result. The result sits in an
// output register, so the next transaction is accepted while a result still
// waits on out_stall.
module generational_handle_pool (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_req_type,
  input  logic [ghp_pkg::IDX_W-1:0]      in_handle_index,
  input  logic [ghp_pkg::GEN_BITS-1:0]   in_handle_generation,
  input  logic [ghp_pkg::PAYLOAD_BITS-1:0] in_payload,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_status,
  output logic [ghp_pkg::IDX_W-1:0]      out_index,
  output logic [ghp_pkg::GEN_BITS-1:0]   out_generation,
  output logic [ghp_pkg::PAYLOAD_BITS-1:0] out_payload
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state_r, state_nxt;

  // Latched request
  logic [1:0]    req_r;
  ghp_pkg::gen_t req_gen_r;
  ghp_pkg::pay_t req_pay_r;
  ghp_pkg::idx_t slot_r, slot_nxt;

  // Scan position
  logic [ghp_pkg::CHUNK_W-1:0] chunk_r, chunk_nxt;

  // Per-slot flags
  logic [ghp_pkg::SLOT_COUNT-1:0] alive_r;
  logic [ghp_pkg::SLOT_COUNT-1:0] gen_vld_r;

  // Slot memories with registered read data
  ghp_pkg::gen_t gen_mem [ghp_pkg::SLOT_COUNT];
  ghp_pkg::pay_t pay_mem [ghp_pkg::SLOT_COUNT];
  ghp_pkg::gen_t gen_rd_r;
  ghp_pkg::pay_t pay_rd_r;

  // Output register
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  ghp_pkg::idx_t out_index_r;
  ghp_pkg::gen_t out_generation_r;
  ghp_pkg::pay_t out_payload_r;

  logic in_acc;
  logic load_out;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign load_out = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // Priority encoder over the current group of alive flags
  logic [ghp_pkg::SCAN_W-1:0]   free_chunk;
  logic [ghp_pkg::SCAN_LSB-1:0] free_pos;
  logic                         free_any;

  always_comb begin
    free_chunk = ~alive_r[chunk_r * ghp_pkg::SCAN_W +: ghp_pkg::SCAN_W];
    free_any   = |free_chunk;
    free_pos   = '0;
    for (int i = ghp_pkg::SCAN_W - 1; i >= 0; i--) begin
      if (free_chunk[i]) begin
        free_pos = ghp_pkg::SCAN_LSB'(i);
      end
    end
  end

  // Execute-stage decode: effective generation, handle check, next generation
  ghp_pkg::gen_t gen_eff;
  ghp_pkg::gen_t gen_inc;
  ghp_pkg::gen_t gen_new;
  logic          handle_ok;
  logic          scan_full_r;

  always_comb begin
    gen_eff   = gen_vld_r[slot_r] ? gen_rd_r : '0;
    gen_inc   = gen_eff + ghp_pkg::gen_t'(1);
    gen_new   = (gen_inc == '0) ? ghp_pkg::gen_t'(1) : gen_inc;
    handle_ok = (req_gen_r != '0)
             && ({1'b0, slot_r} < (ghp_pkg::IDX_W + 1)'(ghp_pkg::SLOT_COUNT))
             && alive_r[slot_r]
             && (gen_eff == req_gen_r);
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    chunk_nxt = chunk_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          slot_nxt  = in_handle_index;
          chunk_nxt = '0;
          state_nxt = (in_req_type == ghp_pkg::REQ_CREATE) ? S_SCAN : S_READ;
        end
      end
      S_SCAN: begin
        if (free_any) begin
          slot_nxt  = {chunk_r, free_pos};
          state_nxt = S_READ;
        end else if (chunk_r == ghp_pkg::CHUNK_W'(ghp_pkg::CHUNKS - 1)) begin
          state_nxt = S_EXEC;
        end else begin
          chunk_nxt = chunk_r + 1'b1;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chunk_r     <= '0;
      scan_full_r <= 1'b0;
      alive_r     <= '0;
      gen_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chunk_r <= chunk_nxt;
      // pool full only once the last group has no free slot
      if (in_acc) begin
        scan_full_r <= 1'b0;
      end else if (state_r == S_SCAN && !free_any
                   && chunk_r == ghp_pkg::CHUNK_W'(ghp_pkg::CHUNKS - 1)) begin
        scan_full_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (load_out && req_r == ghp_pkg::REQ_CREATE && !scan_full_r) begin
        alive_r[slot_r]   <= 1'b1;
        gen_vld_r[slot_r] <= 1'b1;
      end else if (load_out && req_r == ghp_pkg::REQ_DESTROY && handle_ok) begin
        alive_r[slot_r] <= 1'b0;
      end
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    if (in_acc) begin
      req_r     <= in_req_type;
      req_gen_r <= in_handle_generation;
      req_pay_r <= in_payload;
    end
  end

  // Slot memories: read in S_READ, written in S_EXEC
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      gen_rd_r <= gen_mem[slot_r];
      pay_rd_r <= pay_mem[slot_r];
    end
    if (load_out && req_r == ghp_pkg::REQ_CREATE && !scan_full_r) begin
      gen_mem[slot_r] <= gen_new;
      pay_mem[slot_r] <= req_pay_r;
    end else if (load_out && handle_ok && req_r == ghp_pkg::REQ_UPDATE) begin
      pay_mem[slot_r] <= req_pay_r;
    end else if (load_out && handle_ok && req_r == ghp_pkg::REQ_DESTROY) begin
      pay_mem[slot_r] <= '0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r     <= ghp_pkg::STAT_OK;
      out_index_r      <= '0;
      out_generation_r <= '0;
      out_payload_r    <= '0;
      if (req_r == ghp_pkg::REQ_CREATE) begin
        if (scan_full_r) begin
          out_status_r <= ghp_pkg::STAT_FULL;
        end else begin
          out_index_r      <= slot_r;
          out_generation_r <= gen_new;
        end
      end else if (!handle_ok) begin
        out_status_r <= ghp_pkg::STAT_BAD;
      end else if (req_r == ghp_pkg::REQ_LOOKUP) begin
        out_payload_r <= pay_rd_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_index      = out_index_r;
  assign out_generation = out_generation_r;
  assign out_payload    = out_payload_r;

  // Checks
  a_scan_only_create: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (req_r == ghp_pkg::REQ_CREATE))
    else $error("free-slot scan running for a non-create request");

  a_create_marks_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && req_r == ghp_pkg::REQ_CREATE && !scan_full_r) |=> alive_r[slot_r])
    else $error("created slot not marked alive");

  a_create_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && req_r == ghp_pkg::REQ_CREATE && !scan_full_r)
      |=> (out_generation_r != '0))
    else $error("create returned generation zero");

  a_full_only_create: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_status_r != ghp_pkg::STAT_FULL
                  || $past(req_r) == ghp_pkg::REQ_CREATE))
    else $error("pool-full status for a non-create request");

  a_full_really_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && req_r == ghp_pkg::REQ_CREATE && scan_full_r) |-> (&alive_r))
    else $error("pool-full reported with a free slot");

endmodule

// ===== tb/sv/generational_handle_pool_tb.sv =====
// Self-checking testbench for generational_handle_pool: directed table, slot reuse,
// pool fill, then random create/update/destroy/lookup traffic checked by a pool predictor.
// Depends on ghp_pkg and the generational_handle_pool RTL.
`timescale 1ns / 1ps

module generational_handle_pool_tb;

  localparam int RUN_LIMIT    = 3000000;
  localparam int RANDOM_ITEMS = 760;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [1:0]    status;
    ghp_pkg::idx_t index;
    ghp_pkg::gen_t generation;
    ghp_pkg::pay_t payload;
  } pool_result_t;

  // Setup run before a directed row
  typedef enum logic [1:0] {PREP_NONE, PREP_FILL} prep_t;

  typedef struct packed {
    prep_t         prep;
    logic [1:0]    req;
    ghp_pkg::idx_t idx;
    ghp_pkg::gen_t gen;
    ghp_pkg::pay_t pay;
    logic          fixed;
    pool_result_t  result;
  } directed_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [1:0]    in_req_type = ghp_pkg::REQ_CREATE;
  ghp_pkg::idx_t in_handle_index = '0;
  ghp_pkg::gen_t in_handle_generation = '0;
  ghp_pkg::pay_t in_payload = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    out_status;
  ghp_pkg::idx_t out_index;
  ghp_pkg::gen_t out_generation;
  ghp_pkg::pay_t out_payload;

  // Predicted pool contents
  bit            slot_alive [ghp_pkg::SLOT_COUNT];
  ghp_pkg::gen_t slot_gen   [ghp_pkg::SLOT_COUNT] = '{default: '0};
  ghp_pkg::pay_t slot_pay   [ghp_pkg::SLOT_COUNT];

  pool_result_t pending_results[$];
  int error_count = 0;
  int items_sent = 0;
  int n_ok = 0, n_bad = 0, n_full = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;

  // Receiver state
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_phase = 0;
  int stall_mode = 0;

  // Directed rows; fixed rows carry the expected result, the rest use the predictor
  directed_row_t plan [0:25] = '{
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd0,  16'd1,    32'd0,         1'b1,
      '{ghp_pkg::STAT_BAD, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_CREATE,  6'd63, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
      '{ghp_pkg::STAT_OK, 6'd0, 16'd1, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_CREATE,  6'd0,  16'd0,    32'd0,         1'b1,
      '{ghp_pkg::STAT_OK, 6'd1, 16'd1, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd0,  16'd1,    32'd0,         1'b1,
      '{ghp_pkg::STAT_OK, 6'd0, 16'd0, 32'hFFFF_FFFF}},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd1,  16'd1,    32'hFFFF_FFFF, 1'b1,
      '{ghp_pkg::STAT_OK, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd0,  16'd0,    32'd0,         1'b1,
      '{ghp_pkg::STAT_BAD, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd63, 16'hFFFF, 32'd0,         1'b1,
      '{ghp_pkg::STAT_BAD, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_UPDATE,  6'd0,  16'd1,    32'hA5A5_5A5A, 1'b0, '0},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd0,  16'd1,    32'd0,         1'b0, '0},
    '{PREP_NONE, ghp_pkg::REQ_UPDATE,  6'd0,  16'd2,    32'h0F0F_0F0F, 1'b1,
      '{ghp_pkg::STAT_BAD, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_DESTROY, 6'd0,  16'd1,    32'd0,         1'b1,
      '{ghp_pkg::STAT_OK, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd0,  16'd1,    32'd0,         1'b1,
      '{ghp_pkg::STAT_BAD, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_DESTROY, 6'd0,  16'd1,    32'd0,         1'b1,
      '{ghp_pkg::STAT_BAD, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_CREATE,  6'd5,  16'd7,    32'h1234_5678, 1'b0, '0},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd0,  16'd1,    32'd0,         1'b1,
      '{ghp_pkg::STAT_BAD, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd0,  16'd2,    32'd0,         1'b0, '0},
    '{PREP_NONE, ghp_pkg::REQ_UPDATE,  6'd1,  16'd0,    32'hDEAD_BEEF, 1'b1,
      '{ghp_pkg::STAT_BAD, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_DESTROY, 6'd0,  16'd2,    32'd0,         1'b0, '0},
    // slot 0 taken a third time: generation 3
    '{PREP_NONE, ghp_pkg::REQ_CREATE,  6'd0,  16'd0,    32'h5A5A_A5A5, 1'b1,
      '{ghp_pkg::STAT_OK, 6'd0, 16'd3, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd0,  16'hFFFF, 32'd0,         1'b1,
      '{ghp_pkg::STAT_BAD, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd0,  16'd3,    32'd0,         1'b1,
      '{ghp_pkg::STAT_OK, 6'd0, 16'd0, 32'h5A5A_A5A5}},
    // every slot taken first
    '{PREP_FILL, ghp_pkg::REQ_CREATE,  6'd0,  16'd0,    32'hFFFF_FFFF, 1'b1,
      '{ghp_pkg::STAT_FULL, 6'd0, 16'd0, 32'd0}},
    '{PREP_NONE, ghp_pkg::REQ_UPDATE,  6'd63, 16'd1,    32'h8000_0001, 1'b0, '0},
    '{PREP_NONE, ghp_pkg::REQ_DESTROY, 6'd63, 16'd1,    32'd0,         1'b0, '0},
    '{PREP_NONE, ghp_pkg::REQ_CREATE,  6'd0,  16'd0,    32'h7FFF_FFFE, 1'b0, '0},
    '{PREP_NONE, ghp_pkg::REQ_LOOKUP,  6'd63, 16'd2,    32'd0,         1'b0, '0}
  };

  generational_handle_pool dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_handle_index      (in_handle_index),
    .in_handle_generation (in_handle_generation),
    .in_payload           (in_payload),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_index            (out_index),
    .out_generation       (out_generation),
    .out_payload          (out_payload)
  );

  always #1 clk = ~clk;

  // Pool predictor: applies one request to the predicted state, returns its result
  function automatic pool_result_t pool_apply(logic [1:0] req, ghp_pkg::idx_t idx,
                                              ghp_pkg::gen_t gen, ghp_pkg::pay_t pay);
    pool_result_t  res;
    bit            found;
    ghp_pkg::gen_t next_gen;
    res = '0;
    found = 1'b0;
    if (req == ghp_pkg::REQ_CREATE) begin
      for (int i = 0; i < ghp_pkg::SLOT_COUNT; i++) begin
        if (!found && !slot_alive[i]) begin
          next_gen = slot_gen[i] + 1'b1;
          if (next_gen == '0) next_gen = 1;
          slot_gen[i]    = next_gen;
          slot_pay[i]    = pay;
          slot_alive[i]  = 1'b1;
          res.index      = ghp_pkg::idx_t'(i);
          res.generation = next_gen;
          found = 1'b1;
        end
      end
      if (!found) res.status = ghp_pkg::STAT_FULL;
    end else if (gen == '0 || int'(idx) >= ghp_pkg::SLOT_COUNT || !slot_alive[idx] ||
                 slot_gen[idx] != gen) begin
      res.status = ghp_pkg::STAT_BAD;
    end else begin
      case (req)
        ghp_pkg::REQ_UPDATE: slot_pay[idx] = pay;
        ghp_pkg::REQ_DESTROY: begin
          slot_pay[idx]   = '0;
          slot_alive[idx] = 1'b0;
        end
        default: res.payload = slot_pay[idx];
      endcase
    end
    case (res.status)
      ghp_pkg::STAT_OK:  n_ok++;
      ghp_pkg::STAT_BAD: n_bad++;
      default:           n_full++;
    endcase
    return res;
  endfunction

  // Offer one transaction, wait for acceptance, record its expected result, then pace
  task automatic issue_request(input logic [1:0] req, input ghp_pkg::idx_t idx,
                               input ghp_pkg::gen_t gen, input ghp_pkg::pay_t pay,
                               input bit fixed, input pool_result_t fixed_result);
    pool_result_t predicted;
    in_valid             <= 1'b1;
    in_req_type          <= req;
    in_handle_index      <= idx;
    in_handle_generation <= gen;
    in_payload           <= pay;
    do @(posedge clk); while (in_stall);
    predicted = pool_apply(req, idx, gen, pay);
    pending_results.push_back(fixed ? fixed_result : predicted);
    items_sent++;
    // bursts of random length, random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 6);
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    pool_result_t got;
    pool_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_index, out_generation, out_payload};
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: status %0d index %0d", got.status,
               got.index);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          error_count++;
        end
        if (got.index != want.index) begin
          $error("out_index: expected %0d, got %0d", want.index, got.index);
          error_count++;
        end
        if (got.generation != want.generation) begin
          $error("out_generation: expected 0x%h, got 0x%h", want.generation,
                 got.generation);
          error_count++;
        end
        if (got.payload != want.payload) begin
          $error("out_payload: expected 0x%h, got 0x%h", want.payload, got.payload);
          error_count++;
        end
      end
    end
  end

  // Receiver stall: one long hold-off on request, otherwise a changing pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (stall_phase == 0) begin
        stall_mode  <= $urandom_range(0, 3);
        stall_phase <= 47;
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 9) < 4);
        2:       out_stall <= ((stall_phase % 5) < 2);
        default: out_stall <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int            live_slots[$];
    int            pick;
    int            create_weight;
    int            roll;
    logic [1:0]    req;
    ghp_pkg::idx_t idx;
    ghp_pkg::gen_t gen;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (plan[r]) begin
      case (plan[r].prep)
        PREP_FILL: begin
          for (int i = 0; i < ghp_pkg::SLOT_COUNT; i++)
            if (!slot_alive[i])
              issue_request(ghp_pkg::REQ_CREATE, ghp_pkg::idx_t'($urandom),
                            ghp_pkg::gen_t'($urandom), $urandom, 1'b0, '0);
        end
        default: ;
      endcase
      issue_request(plan[r].req, plan[r].idx, plan[r].gen, plan[r].pay, plan[r].fixed,
                    plan[r].result);
    end

    // Random traffic: mostly live handles, some stale or garbage handles
    hold_request = 1'b1;
    create_weight = 15;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate fill-up and drain phases so the pool runs full now and then
      if (n % 100 == 0) create_weight = (create_weight == 45) ? 15 : 45;
      // sender pause until everything outstanding has come back
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      live_slots.delete();
      for (int i = 0; i < ghp_pkg::SLOT_COUNT; i++)
        if (slot_alive[i]) live_slots.push_back(i);
      roll = $urandom_range(0, 99);
      idx  = ghp_pkg::idx_t'($urandom);
      gen  = ghp_pkg::gen_t'($urandom);
      if (roll < create_weight) begin
        req = ghp_pkg::REQ_CREATE;
      end else if (roll < 90 && live_slots.size() > 0) begin
        req  = 2'($urandom_range(ghp_pkg::REQ_UPDATE, ghp_pkg::REQ_LOOKUP));
        pick = live_slots[$urandom_range(0, live_slots.size() - 1)];
        idx  = ghp_pkg::idx_t'(pick);
        gen  = slot_gen[pick];
      end else begin
        req = 2'($urandom_range(ghp_pkg::REQ_UPDATE, ghp_pkg::REQ_LOOKUP));
        case ($urandom_range(0, 3))
          0:       gen = '0;
          1:       gen = slot_gen[idx];
          2:       gen = slot_gen[idx] - 1'b1;
          default: ;
        endcase
      end
      issue_request(req, idx, gen, $urandom, 1'b0, '0);
    end

    // Drain
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (16) @(posedge clk);

    $display("Sent %0d requests: directed cases, slot reuse, full pool, random traffic",
             items_sent);
    $display("Outcomes: %0d ok, %0d bad handle, %0d pool full", n_ok, n_bad, n_full);
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ghp_pkg.sv
rtl/core/generational_handle_pool.sv
tb/sv/generational_handle_pool_tb.sv
